FILE: rtl/core/u2u_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants of the UTF-8 to UTF-16 decoder.
// -----------------------------------------------------------------------------
package u2u_pkg;

  // Depth of the event queue between the front and back parts
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;

  localparam int unsigned PointW = 21;
  localparam int unsigned UnitW  = 16;

  localparam logic [PointW-1:0] SurrFirst = 21'h00D800;
  localparam logic [PointW-1:0] SurrLast  = 21'h00DFFF;
  localparam logic [PointW-1:0] MaxPoint  = 21'h10FFFF;
  localparam logic [PointW-1:0] BmpLast   = 21'h00FFFF;
  localparam logic [PointW-1:0] SuppBase  = 21'h010000;
  localparam logic [UnitW-1:0]  HiSurrBase = 16'hD800;
  localparam logic [UnitW-1:0]  LoSurrBase = 16'hDC00;

  typedef enum logic [2:0] {
    ST_UNIT    = 3'd0,
    ST_STRAY   = 3'd1,
    ST_BADLEAD = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_BADCONT = 3'd4,
    ST_SURR    = 3'd5,
    ST_BIG     = 3'd6
  } status_e;

  // One classified byte that causes results: a finished code point or an error
  typedef struct packed {
    logic [PointW-1:0] point;
    status_e           status;
    logic              eos;
  } event_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    status_e          status;
    logic             run_last;
    logic             string_done;
  } result_t;

  typedef enum logic {
    BK_EVENT,
    BK_LOW
  } bk_state_e;

endpackage
`default_nettype wire

FILE: rtl/core/u2u_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// u2u_front
// Byte classifier: gathers code points from UTF-8 bytes and flags errors.
// -----------------------------------------------------------------------------
module u2u_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      data_byte_i,
  input  wire logic            end_of_string_i,
  output logic                 ev_valid_o,
  output u2u_pkg::event_t      ev_o
);
  import u2u_pkg::*;

  logic [PointW-1:0] point_q, point_d;
  logic [1:0]        pend_q, pend_d;
  logic              discard_q, discard_d;

  logic [PointW-1:0] cont_point;
  logic [1:0]        cont_pend;
  logic              is_cont;

  assign cont_point = {point_q[PointW-7:0], data_byte_i[5:0]};
  assign cont_pend  = pend_q - 2'd1;
  assign is_cont    = (data_byte_i[7:6] == 2'b10);

  always_comb begin
    point_d    = point_q;
    pend_d     = pend_q;
    discard_d  = discard_q;
    ev_valid_o = 1'b0;
    ev_o.point  = '0;
    ev_o.status = ST_UNIT;
    ev_o.eos    = end_of_string_i;

    if (accept_i) begin
      if (discard_q) begin
        if (end_of_string_i) begin
          discard_d = 1'b0;
        end
      end else if (pend_q == 2'd0) begin
        if (!data_byte_i[7]) begin
          ev_valid_o = 1'b1;
          ev_o.point = {{(PointW-8){1'b0}}, data_byte_i};
        end else if (data_byte_i[7:6] == 2'b10) begin
          ev_valid_o  = 1'b1;
          ev_o.status = ST_STRAY;
        end else if (data_byte_i[7:3] == 5'b11111) begin
          ev_valid_o  = 1'b1;
          ev_o.status = ST_BADLEAD;
        end else if (end_of_string_i) begin
          // a lead byte on the end mark can never complete
          ev_valid_o  = 1'b1;
          ev_o.status = ST_TRUNC;
        end else if (data_byte_i[7:5] == 3'b110) begin
          point_d = {{(PointW-5){1'b0}}, data_byte_i[4:0]};
          pend_d  = 2'd1;
        end else if (data_byte_i[7:4] == 4'b1110) begin
          point_d = {{(PointW-4){1'b0}}, data_byte_i[3:0]};
          pend_d  = 2'd2;
        end else begin
          point_d = {{(PointW-3){1'b0}}, data_byte_i[2:0]};
          pend_d  = 2'd3;
        end
      end else if (!is_cont) begin
        ev_valid_o  = 1'b1;
        ev_o.status = ST_BADCONT;
      end else if (cont_pend == 2'd0) begin
        ev_valid_o = 1'b1;
        point_d    = '0;
        pend_d     = 2'd0;
        if (cont_point >= SurrFirst && cont_point <= SurrLast) begin
          ev_o.status = ST_SURR;
        end else if (cont_point > MaxPoint) begin
          ev_o.status = ST_BIG;
        end else begin
          ev_o.point = cont_point;
        end
      end else if (end_of_string_i) begin
        ev_valid_o  = 1'b1;
        ev_o.status = ST_TRUNC;
      end else begin
        point_d = cont_point;
        pend_d  = cont_pend;
      end

      // any error resets the gatherer and drops the rest of the string
      if (ev_valid_o && ev_o.status != ST_UNIT) begin
        point_d   = '0;
        pend_d    = 2'd0;
        discard_d = !end_of_string_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q   <= '0;
      pend_q    <= 2'd0;
      discard_q <= 1'b0;
    end else begin
      point_q   <= point_d;
      pend_q    <= pend_d;
      discard_q <= discard_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/u2u_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// u2u_fifo
// Short event queue that decouples the classifier from the unit emitter.
// -----------------------------------------------------------------------------
module u2u_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire u2u_pkg::event_t data_i,
  input  wire logic            pop_i,
  output u2u_pkg::event_t      data_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import u2u_pkg::*;

  event_t               mem [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]  count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FifoPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/u2u_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// u2u_back
// Unit emitter: turns events into UTF-16 units, splitting surrogate pairs.
// -----------------------------------------------------------------------------
module u2u_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            ev_valid_i,
  input  wire u2u_pkg::event_t ev_i,
  output logic                 ev_pop_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output logic [15:0]          code_unit_o,
  output logic [2:0]           status_o,
  output logic                 run_last_o,
  output logic                 string_done_o
);
  import u2u_pkg::*;

  bk_state_e         state_q, state_d;
  logic              out_valid_q, out_valid_d;
  result_t           result_q, result_d;
  logic [9:0]        lo_q, lo_d;
  logic              lo_eos_q, lo_eos_d;

  logic              load_ok;
  logic              is_pair;
  logic [PointW-1:0] supp;

  assign load_ok = !out_valid_q || pop_i;
  assign is_pair = (ev_i.status == ST_UNIT) && (ev_i.point > BmpLast);
  assign supp    = ev_i.point - SuppBase;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_EVENT: begin
        if (load_ok && ev_valid_i && is_pair) begin
          state_d = BK_LOW;
        end
      end
      BK_LOW: begin
        if (load_ok) begin
          state_d = BK_EVENT;
        end
      end
      default: state_d = BK_EVENT;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ev_pop_o    = 1'b0;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    lo_d        = lo_q;
    lo_eos_d    = lo_eos_q;
    case (state_q)
      BK_EVENT: begin
        if (load_ok) begin
          out_valid_d = ev_valid_i;
          ev_pop_o    = ev_valid_i;
          if (ev_i.status != ST_UNIT) begin
            result_d.code_unit   = '0;
            result_d.status      = ev_i.status;
            result_d.run_last    = 1'b1;
            result_d.string_done = 1'b1;
          end else if (is_pair) begin
            result_d.code_unit   = HiSurrBase | {6'b0, supp[19:10]};
            result_d.status      = ST_UNIT;
            result_d.run_last    = 1'b0;
            result_d.string_done = 1'b0;
            lo_d                 = ev_i.point[9:0];
            lo_eos_d             = ev_i.eos;
          end else begin
            result_d.code_unit   = ev_i.point[UnitW-1:0];
            result_d.status      = ST_UNIT;
            result_d.run_last    = 1'b1;
            result_d.string_done = ev_i.eos;
          end
        end
      end
      BK_LOW: begin
        if (load_ok) begin
          out_valid_d          = 1'b1;
          result_d.code_unit   = LoSurrBase | {6'b0, lo_q};
          result_d.status      = ST_UNIT;
          result_d.run_last    = 1'b1;
          result_d.string_done = lo_eos_q;
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_EVENT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    lo_q     <= lo_d;
    lo_eos_q <= lo_eos_d;
  end

  assign empty_o       = !out_valid_q;
  assign code_unit_o   = result_q.code_unit;
  assign status_o      = result_q.status;
  assign run_last_o    = result_q.run_last;
  assign string_done_o = result_q.string_done;

endmodule
`default_nettype wire

FILE: rtl/core/utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream in, UTF-16 code units and error results out.
// -----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle while full is low; the classifier keeps the
// partial code point and puts one event per finished character or error into
// a four-entry queue. The emitter turns each event into one result, or two for
// a point above 0xFFFF (high then low surrogate), so the output side moves one
// unit per cycle while results wait and pop is high. A result is registered
// first in the event queue and then in the emitter's result register. After an
// error result the rest of the string, through the end mark, gives no results.
// Overlong forms are taken as they come.
// -----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_string_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      code_unit_o,
  output logic [2:0]       status_o,
  output logic             run_last_o,
  output logic             string_done_o
);
  import u2u_pkg::*;

  logic   accept;
  logic   fifo_full, fifo_empty, fifo_pop;
  logic   ev_valid;
  event_t ev_in, ev_out;

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  u2u_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .ev_valid_o      (ev_valid),
    .ev_o            (ev_in)
  );

  u2u_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_valid),
    .data_i  (ev_in),
    .pop_i   (fifo_pop),
    .data_o  (ev_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  u2u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_valid_i    (!fifo_empty),
    .ev_i          (ev_out),
    .ev_pop_o      (fifo_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .code_unit_o   (code_unit_o),
    .status_o      (status_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/u2u_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// u2u_checker
// Port-level checks on the decoder's result stream.
// -----------------------------------------------------------------------------
module u2u_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [15:0] code_unit_i,
  input  wire logic [2:0]  status_i,
  input  wire logic        run_last_i,
  input  wire logic        string_done_i
);
  import u2u_pkg::*;

  // a waiting request that is not taken stays as it is
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(code_unit_i) && $stable(status_i)
                          && $stable(run_last_i) && $stable(string_done_i)))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_i != ST_UNIT) |->
      (code_unit_i == '0 && run_last_i && string_done_i))
    else $error("malformed error result");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_i <= ST_BIG))
    else $error("status code out of range");

  // only a high surrogate leaves its character unfinished
  a_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !run_last_i) |->
      (status_i == ST_UNIT && code_unit_i[15:10] == 6'b110110 && !string_done_i))
    else $error("non-final result is not a high surrogate");

  a_low_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !run_last_i) |=>
      (!empty && run_last_i && code_unit_i[15:10] == 6'b110111))
    else $error("low surrogate did not follow at once");

endmodule

bind utf8_to_utf16_decoder u2u_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .code_unit_i   (code_unit_o),
  .status_i      (status_o),
  .run_last_i    (run_last_o),
  .string_done_i (string_done_o)
);
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UTF-16 decoder.
// -----------------------------------------------------------------------------
// Bytes go in through the push/full side, one request per accepted byte. An
// internal transcoder tracks the partial code point and predicts every UTF-16
// unit or error result. The results are popped at random and checked field by
// field against the oldest prediction. Directed strings cover the ASCII
// extremes, all four sequence lengths and every error kind. Random strings
// follow, mostly well formed and partly broken or noise.
// -----------------------------------------------------------------------------
module tb;
  import u2u_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainCycles = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] code_unit;
  logic [2:0]  status;
  logic        run_last;
  logic        string_done;

  // Transcoder state mirrored on the bench side
  logic [20:0] pend_point = '0;
  logic [1:0]  conts_due = '0;
  logic        skip_to_end = 1'b0;
  result_t     expected_units[$];

  logic [7:0]  str_q[$];

  int unsigned in_idle_pct = 15;
  int unsigned out_idle_pct = 15;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned units_checked = 0;
  int unsigned errors_checked = 0;
  int unsigned stall_cycles = 0;

  utf8_to_utf16_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .end_of_string_i (end_of_string),
    .empty           (empty),
    .pop             (pop),
    .code_unit_o     (code_unit),
    .status_o        (status),
    .run_last_o      (run_last),
    .string_done_o   (string_done)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void add_unit(logic [15:0] unit, status_e st, logic last,
                                   logic done);
    result_t r;
    r.code_unit   = unit;
    r.status      = st;
    r.run_last    = last;
    r.string_done = done;
    expected_units.insert(expected_units.size(), r);
  endfunction

  function automatic void flag_error(status_e st, logic eos);
    pend_point  = '0;
    conts_due   = '0;
    skip_to_end = !eos;
    add_unit(16'h0000, st, 1'b1, 1'b1);
  endfunction

  function automatic void finish_point(logic [20:0] cp, logic eos);
    logic [20:0] off;
    pend_point = '0;
    conts_due  = '0;
    off = cp - SuppBase;
    if (cp >= SurrFirst && cp <= SurrLast) begin
      flag_error(ST_SURR, eos);
    end else if (cp > MaxPoint) begin
      flag_error(ST_BIG, eos);
    end else if (cp <= BmpLast) begin
      add_unit(cp[15:0], ST_UNIT, 1'b1, eos);
    end else begin
      add_unit(HiSurrBase + {6'd0, off[19:10]}, ST_UNIT, 1'b0, 1'b0);
      add_unit(LoSurrBase + {6'd0, off[9:0]}, ST_UNIT, 1'b1, eos);
    end
  endfunction

  function automatic void predict_units(logic [7:0] b, logic eos);
    if (skip_to_end) begin
      if (eos) skip_to_end = 1'b0;
      return;
    end
    if (conts_due == 2'd0) begin
      if (b <= 8'h7F) begin
        finish_point({13'd0, b}, eos);
        return;
      end
      if (b <= 8'hBF) begin
        flag_error(ST_STRAY, eos);
        return;
      end
      if (b >= 8'hF8) begin
        flag_error(ST_BADLEAD, eos);
        return;
      end
      if (b <= 8'hDF) begin
        pend_point = {16'd0, b[4:0]};
        conts_due  = 2'd1;
      end else if (b <= 8'hEF) begin
        pend_point = {17'd0, b[3:0]};
        conts_due  = 2'd2;
      end else begin
        pend_point = {18'd0, b[2:0]};
        conts_due  = 2'd3;
      end
      // a lead byte carrying the end mark is already a short sequence
      if (eos) flag_error(ST_TRUNC, eos);
      return;
    end
    if (b[7:6] != 2'b10) begin
      flag_error(ST_BADCONT, eos);
      return;
    end
    pend_point = {pend_point[14:0], b[5:0]};
    conts_due  = conts_due - 2'd1;
    if (conts_due == 2'd0) finish_point(pend_point, eos);
    else if (eos) flag_error(ST_TRUNC, eos);
  endfunction

  // ---------------------------------------------------------------------------
  // String building
  // ---------------------------------------------------------------------------
  function automatic void append_byte(logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  function automatic void add_point(logic [20:0] cp, int unsigned n);
    case (n)
      1: begin
        append_byte({1'b0, cp[6:0]});
      end
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] pick_point(int unsigned lo, int unsigned hi);
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) return lo[20:0];
    if (sel == 1) return hi[20:0];
    return 21'($urandom_range(hi, lo));
  endfunction

  // One valid character of random length; now and then an overlong form
  function automatic void add_random_char();
    int unsigned n;
    logic        overlong;
    logic [20:0] cp;
    n = $urandom_range(1, 4);
    overlong = ($urandom_range(19) == 0);
    case (n)
      1: cp = pick_point(0, 'h7F);
      2: cp = overlong ? pick_point(0, 'h7F) : pick_point('h80, 'h7FF);
      3: begin
        cp = overlong ? pick_point(0, 'h7FF) : pick_point('h800, 'hFFFF);
        if (cp >= SurrFirst && cp <= SurrLast) cp = cp ^ 21'h002000;
      end
      default: cp = overlong ? pick_point(0, 'hD7FF) : pick_point('h10000, 'h10FFFF);
    endcase
    add_point(cp, n);
  endfunction

  function automatic void build_random_string();
    int unsigned nchars;
    int unsigned pos;
    str_q.delete();
    nchars = $urandom_range(1, 6);
    if ($urandom_range(99) < 70) begin
      repeat (nchars) add_random_char();
      return;
    end
    case ($urandom_range(4))
      0: begin
        repeat (nchars) append_byte(8'($urandom_range(255)));
      end
      1: begin
        repeat (nchars) add_random_char();
        pos = $urandom_range(str_q.size() - 1);
        str_q[pos] = 8'($urandom_range(255));
      end
      2: begin
        repeat (nchars - 1) add_random_char();
        append_byte(8'($urandom_range('hF7, 'hC0)));
        if ($urandom_range(1)) append_byte(8'($urandom_range('hBF, 'h80)));
      end
      3: begin
        repeat ($urandom_range(2)) add_random_char();
        add_point(pick_point('hD800, 'hDFFF), 3);
        repeat ($urandom_range(2)) add_random_char();
      end
      default: begin
        repeat ($urandom_range(2)) add_random_char();
        add_point(pick_point('h110000, 'h1FFFFF), 4);
        repeat ($urandom_range(2)) add_random_char();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving; called at a falling edge, returns at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < in_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push          <= 1'b1;
    data_byte     <= b;
    end_of_string <= eos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_units(b, eos);
    bytes_sent++;
    if (eos) strings_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) begin
      send_byte(str_q[i], i == str_q.size() - 1);
    end
  endtask

  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= out_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_units.size() == 0) begin
        $error("result with nothing expected: code_unit %h status %0d", code_unit, status);
        fail_count++;
      end else begin
        want = expected_units.pop_front();
        if (code_unit !== want.code_unit) begin
          $error("code_unit: expected %h, got %h", want.code_unit, code_unit);
          fail_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last);
          fail_count++;
        end
        if (string_done !== want.string_done) begin
          $error("string_done: expected %0b, got %0b", want.string_done, string_done);
          fail_count++;
        end
        units_checked++;
        if (want.status != ST_UNIT) errors_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("timeout: no request moved for %0d cycles", StallLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // ASCII extremes, two, three and four byte forms inside one string
  task automatic test_valid_forms();
    str_q = '{8'h00, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF,
              8'hF0, 8'h90, 8'h80, 8'h80, 8'h7F};
    send_string();
  endtask

  task automatic test_error_kinds();
    str_q = '{8'h80, 8'h41};               // stray continuation, rest dropped
    send_string();
    str_q = '{8'hFF};                      // bad lead
    send_string();
    str_q = '{8'hE0};                      // lead byte at the end mark
    send_string();
    str_q = '{8'hF0, 8'h90};               // cut short mid sequence
    send_string();
    str_q = '{8'hC3, 8'h41, 8'h42};        // bad continuation, rest dropped
    send_string();
    str_q = '{8'hED, 8'hA0, 8'h80};        // encoded surrogate
    send_string();
    str_q = '{8'hF4, 8'h90, 8'h80, 8'h80}; // beyond the last code point
    send_string();
  endtask

  task automatic test_random_strings(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_random_string();
      send_string();
    end
  endtask

  task automatic test_back_to_back();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_strings(300);
    in_idle_pct  = 15;
    out_idle_pct = 15;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_valid_forms();
    test_error_kinds();
    test_random_strings(600);
    test_back_to_back();
    test_random_strings(600);

    push <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d strings; checked %0d results, %0d of them errors.",
             bytes_sent, strings_sent, units_checked, errors_checked);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
